// ----- design/uartrx_pkg.sv -----
// Shared types and constants for the oversampled UART receiver.
package uartrx_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_FRAME     = 2'd1,
    MODE_WAIT_HIGH = 2'd2
  } rx_mode_e;

  localparam logic EV_DATA  = 1'b0;
  localparam logic EV_BREAK = 1'b1;

  localparam logic [7:0] SPB_RESET       = 8'd8;
  localparam logic [7:0] SPB_MIN         = 8'd2;
  localparam logic [3:0] LAST_DATA_INDEX = 4'd8;
  localparam logic [3:0] START_INDEX     = 4'd0;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } rx_event_t;

  typedef struct packed {
    logic      valid;
    rx_event_t ev;
  } rx_result_t;

endpackage

// ----- design/uartrx_core.sv -----
// Frame state machine: bit cell timing, data shifting and stop/break decisions.
module uartrx_core #(
  parameter int unsigned MAX_SAMPLES_PER_BIT = 255
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  in_fire_i,
  input  logic                  level_i,
  output uartrx_pkg::rx_result_t res_o
);

  uartrx_pkg::rx_mode_e mode_q, mode_d;
  logic [7:0] phase_q, phase_d;
  logic [3:0] idx_q, idx_d;
  logic [7:0] word_q, word_d;
  logic [7:0] spb_q;

  logic [7:0] cell_len;
  logic [7:0] half_len;
  logic [7:0] phase_inc;
  logic       cell_wrap;
  logic [7:0] phase_adv;
  logic [3:0] idx_adv;
  logic       at_mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q   <= uartrx_pkg::SPB_RESET;
      mode_q  <= uartrx_pkg::MODE_IDLE;
      phase_q <= '0;
      idx_q   <= '0;
      word_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        spb_q <= cfg_wdata_i;
      end
      mode_q  <= mode_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      word_q  <= word_d;
    end
  end

  // Clamp the programmed cell length to the supported range.
  always_comb begin
    if (spb_q < uartrx_pkg::SPB_MIN) begin
      cell_len = uartrx_pkg::SPB_MIN;
    end else if ({8'h00, spb_q} > 16'(MAX_SAMPLES_PER_BIT)) begin
      cell_len = 8'(MAX_SAMPLES_PER_BIT);
    end else begin
      cell_len = spb_q;
    end
  end

  assign half_len  = {1'b0, cell_len[7:1]};
  assign phase_inc = phase_q + 8'd1;
  assign cell_wrap = (phase_inc >= cell_len);
  assign phase_adv = cell_wrap ? 8'd0 : phase_inc;
  assign idx_adv   = cell_wrap ? (idx_q + 4'd1) : idx_q;
  assign at_mid    = (phase_adv == half_len);

  // Next state.
  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    word_d  = word_q;
    if (in_fire_i) begin
      case (mode_q)
        uartrx_pkg::MODE_WAIT_HIGH: begin
          if (level_i) begin
            mode_d = uartrx_pkg::MODE_IDLE;
          end
        end
        uartrx_pkg::MODE_FRAME: begin
          phase_d = phase_adv;
          idx_d   = idx_adv;
          if (at_mid) begin
            if (idx_adv == uartrx_pkg::START_INDEX) begin
              if (level_i) begin
                mode_d = uartrx_pkg::MODE_IDLE;
              end
            end else if (idx_adv <= uartrx_pkg::LAST_DATA_INDEX) begin
              word_d = {level_i, word_q[7:1]};
            end else begin
              mode_d = level_i ? uartrx_pkg::MODE_IDLE : uartrx_pkg::MODE_WAIT_HIGH;
            end
          end
        end
        default: begin
          mode_d = uartrx_pkg::MODE_IDLE;
          if (!level_i) begin
            mode_d  = uartrx_pkg::MODE_FRAME;
            phase_d = '0;
            idx_d   = '0;
            word_d  = '0;
          end
        end
      endcase
    end
  end

  // Result of the current sample.
  always_comb begin
    res_o.valid   = 1'b0;
    res_o.ev.kind = uartrx_pkg::EV_DATA;
    res_o.ev.data = word_q;
    case (mode_q)
      uartrx_pkg::MODE_WAIT_HIGH: begin
        if (in_fire_i && level_i && (word_q == 8'h00)) begin
          res_o.valid   = 1'b1;
          res_o.ev.kind = uartrx_pkg::EV_BREAK;
          res_o.ev.data = 8'h00;
        end
      end
      uartrx_pkg::MODE_FRAME: begin
        if (in_fire_i && at_mid && level_i && (idx_adv > uartrx_pkg::LAST_DATA_INDEX)) begin
          res_o.valid = 1'b1;
        end
      end
      default: begin
        res_o.valid = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_break_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ev.kind == uartrx_pkg::EV_BREAK) |-> (res_o.ev.data == 8'h00))
    else $error("break result with nonzero data");

  a_wait_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == uartrx_pkg::MODE_WAIT_HIGH && in_fire_i && level_i)
      |=> (mode_q == uartrx_pkg::MODE_IDLE))
    else $error("high line did not end the stop wait");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == uartrx_pkg::MODE_IDLE && in_fire_i && !level_i)
      |=> (mode_q == uartrx_pkg::MODE_FRAME && phase_q == 8'd0 && idx_q == 4'd0
           && word_q == 8'h00))
    else $error("frame start did not clear the frame state");
`endif

endmodule

// ----- design/uartrx_outbuf.sv -----
// Two-entry output buffer: result register plus skid register.
module uartrx_outbuf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  uartrx_pkg::rx_result_t res_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output uartrx_pkg::rx_event_t  out_ev_o
);

  logic                  main_v_q, main_v_d;
  logic                  skid_v_q, skid_v_d;
  uartrx_pkg::rx_event_t main_q, main_d;
  uartrx_pkg::rx_event_t skid_q, skid_d;
  logic                  pop;

  assign pop = main_v_q && !out_stall_i;

  always_comb begin
    main_v_d = main_v_q;
    main_d   = main_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!main_v_q || pop) begin
      if (skid_v_q) begin
        main_v_d = 1'b1;
        main_d   = skid_q;
        skid_v_d = res_i.valid;
        skid_d   = res_i.ev;
      end else begin
        main_v_d = res_i.valid;
        main_d   = res_i.ev;
      end
    end else if (res_i.valid) begin
      skid_v_d = 1'b1;
      skid_d   = res_i.ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_ev_o    = main_q;

`ifndef SYNTHESIS
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held without a result entry");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && main_v_q && out_stall_i) |=> ($stable(skid_q) && skid_v_q))
    else $error("skid entry lost while the output is stalled");
`endif

endmodule

// ----- design/uart_rx_oversampled_with_break.sv -----
// Oversampled 8N1 UART receiver with break detection, top level.
// Throughput: one line sample is accepted every cycle unless the skid register is full.
// A completed result is registered in the result or skid register before it is offered.
// A two-entry output buffer keeps input flowing while one result waits to be taken.
// Reset (asynchronous, active low): receiver idle, samples per bit 8, output buffer empty.
module uart_rx_oversampled_with_break #(
  parameter int unsigned MAX_SAMPLES_PER_BIT = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       line_level_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       event_kind_o,
  output logic [7:0] data_byte_o
);

  uartrx_pkg::rx_result_t res;
  uartrx_pkg::rx_event_t  out_ev;
  logic                   buf_full;
  logic                   in_fire;

  // A sample is transferred whenever the skid register is free.
  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i && !buf_full;

  uartrx_core #(
    .MAX_SAMPLES_PER_BIT(MAX_SAMPLES_PER_BIT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_fire_i  (in_fire),
    .level_i    (line_level_i),
    .res_o      (res)
  );

  uartrx_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_ev_o   (out_ev)
  );

  assign event_kind_o = out_ev.kind;
  assign data_byte_o  = out_ev.data;

endmodule
